@@ rtl/slt_pkg.sv @@
// Shared request/status codes and controller-datapath interface types.
package slt_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_NOP    = 2'd3
  } slt_req_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } slt_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new word and set up the scan index
    logic rd;      // read the table entry at the scan index (one below it for insert)
    logic ev;      // evaluate the entry read, shift and step the index
    logic finish;  // commit count, sum and final write; present the result
  } slt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more;    // another entry must be visited
  } slt_sts_t;

endpackage

@@ rtl/slt_ctrl.sv @@
// Sequencer for the table scan: load, then read/evaluate pairs, then finish.
module slt_ctrl
  import slt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  slt_sts_t sts_i,
  output slt_cmd_t cmd_o,
  output logic     busy_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    busy_d  = busy_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
          busy_d     = 1'b1;
        end
      end
      S_SCAN: begin
        if (sts_i.more) begin
          cmd_o.rd = 1'b1;
          state_d  = S_EVAL;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
          busy_d       = 1'b0;
        end
      end
      S_EVAL: begin
        cmd_o.ev = 1'b1;
        state_d  = S_SCAN;
      end
      default: begin
        state_d = S_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

@@ rtl/slt_dp.sv @@
// Table memory, scan index, entry count, running sum and result registers.
module slt_dp
  import slt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] value_i,
  input  slt_cmd_t           cmd_i,
  output slt_sts_t           sts_o,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic               found_o,
  output logic [6:0]         entry_count_o,
  output logic signed [31:0] total_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic [31:0]        mem [CAPACITY];

  slt_req_e           req_q;
  logic signed [31:0] val_q;
  logic [31:0]        rdata_q;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [31:0]        sum_q, sum_d;
  logic               hit_q, hit_d;
  logic               done_q;
  slt_status_e        status_q, status_d;
  logic               found_q, found_d;

  logic               full;
  logic [CW-1:0]      idx_m1;
  logic [CW-1:0]      rd_full;
  logic [IW-1:0]      rd_addr;
  logic               we;
  logic [CW-1:0]      wa_full;
  logic [IW-1:0]      wa;
  logic [31:0]        wd;

  assign full    = (req_q == REQ_INSERT) && (cnt_q == CW'(CAPACITY));
  assign idx_m1  = idx_q - CW'(1);
  assign rd_full = (req_q == REQ_INSERT) ? idx_m1 : idx_q;
  assign rd_addr = rd_full[IW-1:0];
  assign wa      = wa_full[IW-1:0];

  always_comb begin
    case (req_q)
      REQ_INSERT: sts_o.more = !full && !hit_q && (idx_q != '0);
      REQ_SEARCH: sts_o.more = !hit_q && (idx_q != cnt_q);
      REQ_DELETE: sts_o.more = (idx_q != cnt_q);
      default:    sts_o.more = 1'b0;
    endcase
  end

  always_comb begin
    idx_d    = idx_q;
    hit_d    = hit_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    status_d = ST_DONE;
    found_d  = 1'b0;
    we       = 1'b0;
    wa_full  = idx_q;
    wd       = rdata_q;

    if (cmd_i.load) begin
      hit_d = 1'b0;
      idx_d = (slt_req_e'(req_type_i) == REQ_INSERT) ? cnt_q : '0;
    end

    if (cmd_i.ev) begin
      case (req_q)
        REQ_INSERT: begin
          // Shift larger or equal entries up; stop at the first smaller one.
          if ($signed(rdata_q) >= val_q) begin
            we    = 1'b1;
            idx_d = idx_m1;
          end else begin
            hit_d = 1'b1;
          end
        end
        REQ_SEARCH: begin
          if (rdata_q == val_q) hit_d = 1'b1;
          idx_d = idx_q + CW'(1);
        end
        REQ_DELETE: begin
          // After the first match, pull each later entry down one place.
          if (hit_q) begin
            we      = 1'b1;
            wa_full = idx_m1;
          end else if (rdata_q == val_q) begin
            hit_d = 1'b1;
          end
          idx_d = idx_q + CW'(1);
        end
        default: ;
      endcase
    end

    if (cmd_i.finish) begin
      case (req_q)
        REQ_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            we    = 1'b1;
            wd    = val_q;
            cnt_d = cnt_q + CW'(1);
            sum_d = sum_q + val_q;
          end
        end
        REQ_SEARCH: begin
          status_d = hit_q ? ST_DONE : ST_MISS;
          found_d  = hit_q;
        end
        REQ_DELETE: begin
          if (cnt_q == '0) begin
            status_d = ST_EMPTY;
          end else if (hit_q) begin
            found_d = 1'b1;
            cnt_d   = cnt_q - CW'(1);
            sum_d   = sum_q - val_q;
          end else begin
            status_d = ST_MISS;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (cmd_i.rd) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= slt_req_e'(req_type_i);
      val_q <= value_i;
    end
    if (cmd_i.finish) begin
      status_q <= status_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      hit_q  <= 1'b0;
      cnt_q  <= '0;
      sum_q  <= '0;
      done_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      hit_q  <= hit_d;
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      done_q <= cmd_i.finish;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign entry_count_o = 7'(cnt_q);
  assign total_o       = sum_q;

endmodule

@@ rtl/sorted_list_table.sv @@
// Top level of the sorted value table: controller plus datapath.
//
//   channel  | handshake           | words carried
//   ---------+---------------------+-----------------------------------------
//   request  | start_i / busy_o    | req_type_i, value_i
//   result   | done_o (one cycle)  | status_o, found_o, entry_count_o, total_o
//
// One word at a time: a load step, a read step and an evaluate step per table
// entry visited, then a finish step. The table memory has one read port with a
// registered output, so each entry is read first and evaluated after. Insert
// walks down from the top shifting larger or equal entries up; delete walks
// the whole table from the bottom pulling entries down after the match;
// search stops at the first match. done_o pulses on the cycle busy_o drops.
// Reset empties the table at once; no clearing pass is needed since only
// entries below the count are ever read. The receiver cannot stall.
module sorted_list_table
  import slt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic               found_o,
  output logic [6:0]         entry_count_o,
  output logic signed [31:0] total_o
);

  slt_cmd_t cmd;
  slt_sts_t sts;

  // Sequencer: one load, read/evaluate pairs while entries remain, one finish.
  slt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Table store, scan index, count, sum and the result registers.
  slt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_type_i    (req_type_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_o       (found_o),
    .entry_count_o (entry_count_o),
    .total_o       (total_o)
  );

endmodule

@@ rtl/slt_checker.sv @@
// Port-level checks for the sorted value table, bound to the top level.
module slt_port_checker
  import slt_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic [1:0]         status_o,
  input logic               found_o,
  input logic [6:0]         entry_count_o,
  input logic signed [31:0] total_o
);

  // A result only appears as the block goes idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // An accepted word keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("word accepted but block not busy");

  // A found flag only goes with a done status.
  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (status_o == ST_DONE))
    else $error("found flag with failing status");

  // Without a new word the table contents, and so count and sum, hold.
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && !start_i && !done_o) |=> ($stable(entry_count_o) && $stable(total_o)))
    else $error("count or sum changed while idle");

endmodule

bind sorted_list_table slt_port_checker u_slt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .status_o      (status_o),
  .found_o       (found_o),
  .entry_count_o (entry_count_o),
  .total_o       (total_o)
);

@@ tb/sv/slt_checker.sv @@
// Checker for the sorted value table: predicts each result word and compares it.
module slt_checker
  import slt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] value_i,
  input  logic               done_i,
  input  logic [1:0]         status_i,
  input  logic               found_i,
  input  logic [6:0]         entry_count_i,
  input  logic signed [31:0] total_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    slt_status_e status;
    logic        found;
    logic [6:0]  count;
    logic [31:0] total;
  } slt_result_t;

  // Shadow copy of the table, kept sorted ascending.
  logic signed [31:0] shadow_vals [CAPACITY];
  int                 shadow_held;
  logic [31:0]        shadow_sum;

  slt_result_t        expected_results [$];
  slt_result_t        want;
  int                 mismatches;

  function automatic slt_result_t sorted_table_update(slt_req_e req, logic signed [31:0] v);
    slt_result_t r;
    int          pos;
    int          k;
    r.status = ST_DONE;
    r.found  = 1'b0;
    case (req)
      REQ_INSERT: begin
        if (shadow_held >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_held && shadow_vals[pos] < v) pos++;
          for (k = shadow_held; k > pos; k--) shadow_vals[k] = shadow_vals[k-1];
          shadow_vals[pos] = v;
          shadow_held++;
          shadow_sum += v;
        end
      end
      REQ_SEARCH: begin
        pos = 0;
        while (pos < shadow_held && shadow_vals[pos] != v) pos++;
        if (pos < shadow_held) r.found = 1'b1;
        else r.status = ST_MISS;
      end
      REQ_DELETE: begin
        if (shadow_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = 0;
          while (pos < shadow_held && shadow_vals[pos] != v) pos++;
          if (pos >= shadow_held) begin
            r.status = ST_MISS;
          end else begin
            for (k = pos; k + 1 < shadow_held; k++) shadow_vals[k] = shadow_vals[k+1];
            shadow_held--;
            shadow_sum -= v;
            r.found = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.count = shadow_held[6:0];
    r.total = shadow_sum;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      shadow_held  = 0;
      shadow_sum   = '0;
      mismatches   = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // Compare before accepting: a result word never belongs to a word
      // accepted on the same edge.
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $error("result word with none expected: status %0d count %0d total %0d",
                 status_i, entry_count_i, total_i);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            mismatches++;
          end
          if (found_i !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found_i);
            mismatches++;
          end
          if (entry_count_i !== want.count) begin
            $error("entry_count: expected %0d, actual %0d", want.count, entry_count_i);
            mismatches++;
          end
          if (total_i !== want.total) begin
            $error("total: expected %0d, actual %0d", $signed(want.total), total_i);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_results.push_back(sorted_table_update(slt_req_e'(req_type_i), value_i));
      end
      pending_o    <= expected_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the sorted value table: stimulus, watchdog and verdict.
module tb;
  import slt_pkg::*;

  localparam int CAPACITY = 64;
  // Allow a margin after the last result, beyond the worst-case word.
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 16;
  // 1525 words at worst-case latency plus long sender gaps sit well below this.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEMS_PER_BLOCK = 125;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         req_type_i = REQ_NOP;
  logic signed [31:0] value_i = '0;
  logic               done_o;
  logic [1:0]         status_o;
  logic               found_o;
  logic [6:0]         entry_count_o;
  logic signed [31:0] total_o;

  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;

  // A small pool of values so that searches and deletes hit often, with the
  // extremes in it so that ordering and sum wrap get exercised.
  logic signed [31:0] value_pool [8];
  int                 idle_pct;
  int                 roll;
  bit                 filling;
  slt_req_e           req;
  logic signed [31:0] val;

  sorted_list_table #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .req_type_i,
    .value_i,
    .done_o,
    .status_o,
    .found_o,
    .entry_count_o,
    .total_o
  );

  slt_checker #(
    .CAPACITY(CAPACITY)
  ) u_check (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_i       (busy_o),
    .req_type_i,
    .value_i,
    .done_i       (done_o),
    .status_i     (status_o),
    .found_i      (found_o),
    .entry_count_i(entry_count_o),
    .total_i      (total_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Watchdog: end the run if the block stops answering.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one word and hold it until the block takes it. Before that, drop
  // start for a random gap whose length follows idle_pct. Start stays high on
  // return, so back-to-back words need no extra edge.
  task automatic send_word(input slt_req_e r, input logic signed [31:0] v, input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < pct);
    end
    start_i    <= 1'b1;
    req_type_i <= r;
    value_i    <= v;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start and hold until every expected result word has come back.
  // The first edge lets the checker register the word just accepted.
  task automatic wait_results_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    value_pool[0] = VAL_MIN;
    value_pool[1] = -32'sd2;
    value_pool[2] = -32'sd1;
    value_pool[3] = 32'sd0;
    value_pool[4] = 32'sd1;
    value_pool[5] = 32'sd2;
    value_pool[6] = 32'sd3;
    value_pool[7] = VAL_MAX;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: empty-table cases, no-op code, head insert of a new
    // smallest value, equal entries, hits and misses, sum wrap, then drain.
    send_word(REQ_DELETE, 32'sd5, 0);   // delete from empty table
    send_word(REQ_SEARCH, 32'sd5, 0);   // search miss on empty table
    send_word(REQ_NOP,    VAL_MAX, 0);
    send_word(REQ_INSERT, 32'sd5, 0);
    send_word(REQ_INSERT, 32'sd5, 0);   // equal value goes ahead of the first
    send_word(REQ_INSERT, VAL_MIN, 0);  // new smallest goes to the head
    send_word(REQ_INSERT, VAL_MAX, 0);
    send_word(REQ_INSERT, -32'sd1, 0);
    send_word(REQ_INSERT, 32'sd0, 0);
    send_word(REQ_SEARCH, 32'sd5, 0);
    send_word(REQ_SEARCH, VAL_MAX, 0);
    send_word(REQ_SEARCH, 32'sd7, 0);   // search miss
    send_word(REQ_DELETE, 32'sd5, 0);
    send_word(REQ_DELETE, 32'sd100, 0); // delete miss
    send_word(REQ_DELETE, VAL_MIN, 0);
    send_word(REQ_NOP,    VAL_MIN, 0);
    send_word(REQ_INSERT, VAL_MAX, 0);  // running sum comes back to 2; the next insert wraps it
    send_word(REQ_INSERT, VAL_MAX, 0);
    send_word(REQ_SEARCH, -32'sd1, 0);
    send_word(REQ_DELETE, -32'sd1, 0);
    send_word(REQ_DELETE, 32'sd0, 0);
    send_word(REQ_DELETE, 32'sd5, 0);
    send_word(REQ_DELETE, VAL_MAX, 0);
    send_word(REQ_DELETE, VAL_MAX, 0);
    send_word(REQ_DELETE, VAL_MAX, 0);  // last entry leaves, table empty
    wait_results_drained();

    // Random words in three idling phases: sender gaps of 21, 71, then 0
    // percent. Within each phase, alternate blocks that fill the table past
    // full with blocks that drain it.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 21 : (phase == 1) ? 71 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        filling = (blk % 2 == 0);
        for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
          roll = $urandom_range(0, 99);
          if (filling) begin
            if (roll < 85)      req = REQ_INSERT;
            else if (roll < 93) req = REQ_SEARCH;
            else if (roll < 98) req = REQ_DELETE;
            else                req = REQ_NOP;
          end else begin
            if (roll < 15)      req = REQ_INSERT;
            else if (roll < 35) req = REQ_SEARCH;
            else if (roll < 95) req = REQ_DELETE;
            else                req = REQ_NOP;
          end
          // Mostly pool values so deletes find their target; the rest toggle
          // every bit of the value field.
          if ($urandom_range(0, 99) < 80) val = value_pool[$urandom_range(0, 7)];
          else val = $urandom;
          send_word(req, val, idle_pct);
        end
      end
      // Hold off new words until every result has come back.
      wait_results_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
